>>> design/cle_pkg.sv
// Shared types, codes and sizing for the console line editor.
package cle_pkg;

	localparam int unsigned LINE_CAPACITY_DEF = 4096;

	localparam logic [7:0] KEY_DEL     = 8'd127;
	localparam logic [7:0] KEY_ESC     = 8'd27;
	localparam logic [7:0] KEY_CR      = 8'd13;
	localparam logic [7:0] KEY_LF      = 8'd10;
	localparam logic [7:0] KEY_BRACKET = 8'd91;
	localparam logic [7:0] KEY_RIGHT   = 8'd67;
	localparam logic [7:0] KEY_LEFT    = 8'd68;

	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [3:0] {
		ACT_INSERT   = 4'd0,
		ACT_FULL     = 4'd1,
		ACT_DELETE   = 4'd2,
		ACT_DEL_IGN  = 4'd3,
		ACT_LEFT     = 4'd4,
		ACT_RIGHT    = 4'd5,
		ACT_MOVE_IGN = 4'd6,
		ACT_ESC_PEND = 4'd7,
		ACT_LINE_END = 4'd8,
		ACT_READ     = 4'd9
	} act_t;

	typedef enum logic [1:0] {
		ESC_NONE  = 2'd0,
		ESC_SEEN  = 2'd1,
		ESC_FIRST = 2'd2
	} esc_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_FINAL,
		ST_READ,
		ST_REPLY
	} st_t;

	typedef struct packed {
		act_t act;
		esc_t esc_n;
		logic load_first;
		logic shift;
		logic shift_up;
		logic final_wr;
		logic final_lf;
		logic len_inc;
		logic len_dec;
		logic cur_inc;
		logic cur_dec;
		logic set_done;
	} key_dec_t;

endpackage

>>> design/cle_line_mem.sv
// Line store: one write port, one read port with registered read data.
module cle_line_mem import cle_pkg::*; #(
	parameter int unsigned DEPTH  = LINE_CAPACITY_DEF,
	parameter int unsigned ADDR_W = $clog2(LINE_CAPACITY_DEF)
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [7:0]        rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [7:0]        wr_data
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> design/cle_key_decode.sv
// Key classifier: turns one key byte and the line state into an edit request.
module cle_key_decode import cle_pkg::*; #(
	parameter int unsigned LINE_CAPACITY = LINE_CAPACITY_DEF,
	parameter int unsigned LEN_W         = $clog2(LINE_CAPACITY_DEF + 1),
	parameter int unsigned ADDR_W        = $clog2(LINE_CAPACITY_DEF)
) (
	input  logic [7:0]        key_byte,
	input  logic [LEN_W-1:0]  len,
	input  logic [ADDR_W-1:0] cursor,
	input  esc_t              esc,
	input  logic [7:0]        esc_first,
	output key_dec_t          dec
);

	localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(LINE_CAPACITY - 1);
	localparam logic [LEN_W-1:0] LEN_CAP  = LEN_W'(LINE_CAPACITY);

	logic [LEN_W-1:0] cur_ext;

	assign cur_ext = LEN_W'(cursor);

	always_comb begin
		dec = '0;
		dec.act   = ACT_MOVE_IGN;
		dec.esc_n = ESC_NONE;
		case (esc)
			ESC_SEEN: begin
				dec.load_first = 1'b1;
				dec.esc_n      = ESC_FIRST;
				dec.act        = ACT_ESC_PEND;
			end
			ESC_FIRST: begin
				if (esc_first == KEY_BRACKET && key_byte == KEY_LEFT) begin
					if (cursor != '0) begin
						dec.act     = ACT_LEFT;
						dec.cur_dec = 1'b1;
					end
				end else if (esc_first == KEY_BRACKET && key_byte == KEY_RIGHT) begin
					if (cur_ext < len) begin
						dec.act     = ACT_RIGHT;
						dec.cur_inc = 1'b1;
					end
				end
			end
			default: begin
				if (key_byte == KEY_CR || key_byte == KEY_LF) begin
					dec.act      = ACT_LINE_END;
					dec.set_done = 1'b1;
					dec.final_lf = 1'b1;
					if (len < LEN_CAP) begin
						dec.final_wr = 1'b1;
						dec.len_inc  = 1'b1;
					end
				end else if (key_byte == KEY_DEL) begin
					if (cursor == '0 || len == '0) begin
						dec.act = ACT_DEL_IGN;
					end else begin
						dec.act     = ACT_DELETE;
						dec.shift   = 1'b1;
						dec.len_dec = 1'b1;
						dec.cur_dec = 1'b1;
					end
				end else if (key_byte == KEY_ESC) begin
					dec.act   = ACT_ESC_PEND;
					dec.esc_n = ESC_SEEN;
				end else if (len >= LEN_FULL) begin
					dec.act = ACT_FULL;
				end else begin
					dec.act      = ACT_INSERT;
					dec.shift    = 1'b1;
					dec.shift_up = 1'b1;
					dec.final_wr = 1'b1;
					dec.len_inc  = 1'b1;
					dec.cur_inc  = 1'b1;
				end
			end
		endcase
	end

endmodule

>>> design/console_line_editor_core.sv
// Top level of the console line editor: request sequencer, line state and result register.
//
// One request is taken when start is high and busy is low; exactly one result
// follows, shown for a single cycle with result_valid high, and the receiver
// cannot stall it. The line bytes live in one synchronous memory of
// LINE_CAPACITY bytes with a registered read; insert and delete move the tail of
// the line one byte per cycle through that memory's single read and write port,
// so their requests take longer the further the cursor is from the end of the
// line. A new request may be taken in the same cycle that the previous result
// is shown. After line end the next key request starts a fresh line; read
// requests still see the finished line. No clearing pass is needed after reset:
// only bytes below the current length are ever read, and those were written first.
module console_line_editor_core import cle_pkg::*; #(
	parameter int unsigned LINE_CAPACITY = LINE_CAPACITY_DEF,
	localparam int unsigned LEN_W  = $clog2(LINE_CAPACITY + 1),
	localparam int unsigned ADDR_W = $clog2(LINE_CAPACITY)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              op,
	input  logic [7:0]        key_byte,
	input  logic [ADDR_W-1:0] read_addr,
	output logic              result_valid,
	output logic [3:0]        action,
	output logic [LEN_W-1:0]  line_length,
	output logic [ADDR_W-1:0] cursor_pos,
	output logic              line_done,
	output logic [7:0]        read_byte
);

	// Sequencer state and architectural line state.
	st_t              state_q, state_d;
	logic [LEN_W-1:0]  len_q;
	logic [ADDR_W-1:0] cursor_q;
	esc_t              esc_q;
	logic [7:0]        esc_first_q;
	logic              done_q;

	// Per-request working registers.
	act_t              act_q;
	logic              shift_up_q;
	logic [ADDR_W-1:0] rd_ptr_q;
	logic [LEN_W-1:0]  remain_q;
	logic              final_wr_q;
	logic [ADDR_W-1:0] final_addr_q;
	logic [7:0]        final_data_q;
	logic              in_range_q;
	logic [7:0]        rbyte_q;

	// Shift pipeline: the byte read last cycle is written back here.
	logic              wr_valid_s1;
	logic [ADDR_W-1:0] wr_addr_s1;

	// Memory ports.
	logic              mem_rd_en;
	logic [ADDR_W-1:0] mem_rd_addr;
	logic [7:0]        mem_rd_data;
	logic              mem_wr_en;
	logic [ADDR_W-1:0] mem_wr_addr;
	logic [7:0]        mem_wr_data;

	logic              accept;
	logic              clr_line;
	logic [LEN_W-1:0]  eff_len;
	logic [ADDR_W-1:0] eff_cursor;
	esc_t              eff_esc;
	logic [LEN_W-1:0]  moves;
	key_dec_t          dec;

	// A finished line is dropped by the next key request before it is decoded.
	assign clr_line   = done_q && (op == OP_KEY);
	assign eff_len    = clr_line ? '0 : len_q;
	assign eff_cursor = clr_line ? '0 : cursor_q;
	assign eff_esc    = clr_line ? ESC_NONE : esc_q;
	assign moves      = eff_len - LEN_W'(eff_cursor);

	cle_key_decode #(
		.LINE_CAPACITY(LINE_CAPACITY),
		.LEN_W        (LEN_W),
		.ADDR_W       (ADDR_W)
	) u_decode (
		.key_byte (key_byte),
		.len      (eff_len),
		.cursor   (eff_cursor),
		.esc      (eff_esc),
		.esc_first(esc_first_q),
		.dec      (dec)
	);

	cle_line_mem #(
		.DEPTH (LINE_CAPACITY),
		.ADDR_W(ADDR_W)
	) u_mem (
		.clk    (clk),
		.rd_en  (mem_rd_en),
		.rd_addr(mem_rd_addr),
		.rd_data(mem_rd_data),
		.wr_en  (mem_wr_en),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op == OP_READ) begin
						state_d = ST_READ;
					end else if (dec.shift && moves != '0) begin
						state_d = ST_SHIFT;
					end else if (dec.final_wr) begin
						state_d = ST_FINAL;
					end else begin
						state_d = ST_REPLY;
					end
				end
			end
			ST_SHIFT: begin
				// Leave once the last read is issued; its write lands this cycle.
				if (remain_q == '0) begin
					state_d = final_wr_q ? ST_FINAL : ST_REPLY;
				end
			end
			ST_FINAL: state_d = ST_REPLY;
			ST_READ:  state_d = ST_REPLY;
			ST_REPLY: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: handshake and memory port steering.
	always_comb begin
		busy        = (state_q != ST_IDLE);
		accept      = start && (state_q == ST_IDLE);
		mem_rd_en   = 1'b0;
		mem_rd_addr = rd_ptr_q;
		mem_wr_en   = 1'b0;
		mem_wr_addr = wr_addr_s1;
		mem_wr_data = mem_rd_data;
		case (state_q)
			ST_IDLE: begin
				if (accept && op == OP_READ) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = read_addr;
				end
			end
			ST_SHIFT: begin
				mem_rd_en = (remain_q != '0);
				mem_wr_en = wr_valid_s1;
			end
			ST_FINAL: begin
				mem_wr_en   = final_wr_q;
				mem_wr_addr = final_addr_q;
				mem_wr_data = final_data_q;
			end
			default: begin
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			len_q        <= '0;
			cursor_q     <= '0;
			esc_q        <= ESC_NONE;
			esc_first_q  <= '0;
			done_q       <= 1'b0;
			wr_valid_s1  <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			wr_valid_s1  <= (state_q == ST_SHIFT) && (remain_q != '0);
			result_valid <= (state_q == ST_REPLY);
			if (accept && op == OP_KEY) begin
				// Commit the edit now; the memory catches up over the next cycles.
				len_q <= dec.len_inc ? eff_len + LEN_W'(1) :
				         dec.len_dec ? eff_len - LEN_W'(1) : eff_len;
				cursor_q <= dec.cur_inc ? eff_cursor + ADDR_W'(1) :
				            dec.cur_dec ? eff_cursor - ADDR_W'(1) : eff_cursor;
				esc_q  <= dec.esc_n;
				done_q <= dec.set_done;
				if (dec.load_first) begin
					esc_first_q <= key_byte;
				end
			end
		end
	end

	// Working registers and the shift pipeline address.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q        <= (op == OP_READ) ? ACT_READ : dec.act;
			shift_up_q   <= dec.shift_up;
			remain_q     <= (dec.shift && op == OP_KEY) ? moves : '0;
			rd_ptr_q     <= dec.shift_up ? ADDR_W'(eff_len - LEN_W'(1)) : eff_cursor;
			final_wr_q   <= dec.final_wr && (op == OP_KEY);
			final_addr_q <= dec.final_lf ? ADDR_W'(eff_len) : eff_cursor;
			final_data_q <= dec.final_lf ? KEY_LF : key_byte;
			in_range_q   <= (LEN_W'(read_addr) < len_q);
			rbyte_q      <= '0;
		end
		if (state_q == ST_SHIFT && remain_q != '0) begin
			// Advance: insert walks the tail down, delete walks it up.
			rd_ptr_q   <= shift_up_q ? rd_ptr_q - ADDR_W'(1) : rd_ptr_q + ADDR_W'(1);
			remain_q   <= remain_q - LEN_W'(1);
			wr_addr_s1 <= shift_up_q ? rd_ptr_q + ADDR_W'(1) : rd_ptr_q - ADDR_W'(1);
		end
		if (state_q == ST_READ) begin
			rbyte_q <= in_range_q ? mem_rd_data : '0;
		end
	end

	// Result register: loaded in the reply cycle; result_valid marks it for one cycle.
	always_ff @(posedge clk) begin
		if (state_q == ST_REPLY) begin
			action      <= act_q;
			line_length <= len_q;
			cursor_pos  <= cursor_q;
			line_done   <= done_q;
			read_byte   <= rbyte_q;
		end
	end

endmodule

>>> design/cle_checker.sv
// Port-level checks for the console line editor, bound to the top level.
module cle_checker import cle_pkg::*; #(
	parameter int unsigned LINE_CAPACITY = LINE_CAPACITY_DEF,
	localparam int unsigned LEN_W  = $clog2(LINE_CAPACITY + 1),
	localparam int unsigned ADDR_W = $clog2(LINE_CAPACITY)
) (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              result_valid,
	input logic [3:0]        action,
	input logic [LEN_W-1:0]  line_length,
	input logic [ADDR_W-1:0] cursor_pos,
	input logic              line_done
);

	// An accepted request keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy next cycle");

	// Results never come in adjacent cycles.
	a_result_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("two results in adjacent cycles");

	// The cursor never passes the end of the line.
	a_cursor_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (LEN_W'(cursor_pos) <= line_length))
		else $error("cursor beyond line length");

	// A finished line holds at least its newline.
	a_done_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && line_done) |-> (line_length != '0))
		else $error("line marked done while empty");

	// Only defined action codes are reported.
	a_action_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (action <= ACT_READ))
		else $error("undefined action code");

endmodule

bind console_line_editor_core cle_checker #(
	.LINE_CAPACITY(LINE_CAPACITY)
) u_cle_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.result_valid(result_valid),
	.action      (action),
	.line_length (line_length),
	.cursor_pos  (cursor_pos),
	.line_done   (line_done)
);
